[hdl/wbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbt_pkg
// Shared types, class codes and the word-formation table of the tokenizer.
// ----------------------------------------------------------------------------
package wbt_pkg;

    // character class codes
    localparam logic [3:0] CL_OTHER = 4'd0;
    localparam logic [3:0] CL_SPACE = 4'd1;
    localparam logic [3:0] CL_ALNUM = 4'd2;
    localparam logic [3:0] CL_N     = 4'd3;
    localparam logic [3:0] CL_B     = 4'd4;
    localparam logic [3:0] CL_NUM   = 4'd5;
    localparam logic [3:0] CL_DOT   = 4'd6;
    localparam logic [3:0] CL_COLON = 4'd7;
    localparam logic [3:0] CL_QUOTE = 4'd8;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic [3:0] {
        SC_SPACE = 4'd0,
        SC_OTHER = 4'd1,
        SC_ALNUM = 4'd2,
        SC_N     = 4'd3,
        SC_NB    = 4'd4,
        SC_NBDOT = 4'd5,
        SC_NUM   = 4'd6,
        SC_QUOTE = 4'd7,
        SC_QQ    = 4'd8,
        SC_CMT   = 4'd9
    } t_wbt_scan;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_EMIT  = 2'd1,
        ACT_BEGIN = 2'd2
    } t_wbt_act;

    typedef struct packed {
        t_wbt_scan nxt;
        t_wbt_act  act;
    } t_wbt_cell;

    typedef struct packed {
        logic       opcode;
        logic [3:0] char_class;
    } t_wbt_in;

    typedef struct packed {
        logic        word_valid;
        logic [15:0] word_start;
        logic [15:0] word_length;
        logic        end_of_line;
        logic [15:0] word_count;
        logic        ends_in_comment;
        logic        open_quote_error;
        logic        line_overflow;
    } t_wbt_out;

    // everything one input item produces: pending numeric run, word, terminator
    typedef struct packed {
        logic        has_vec;
        logic [15:0] vec_start;
        logic [15:0] vec_len;
        logic        has_word;
        logic [15:0] word_start;
        logic [15:0] word_len;
        logic        has_term;
        logic [15:0] term_count;
        logic        term_cmt;
        logic        term_oq;
        logic        term_ovf;
    } t_wbt_cmd;

    // state a new token opens with, by class
    function automatic t_wbt_scan wbt_tok_start(input logic [3:0] c);
        t_wbt_scan r;
        unique case (c) inside
            CL_SPACE:         r = SC_SPACE;
            CL_ALNUM, CL_B:   r = SC_ALNUM;
            CL_N:             r = SC_N;
            CL_NUM:           r = SC_NUM;
            CL_QUOTE:         r = SC_QUOTE;
            default:          r = SC_OTHER;
        endcase
        return r;
    endfunction

    function automatic t_wbt_cell wbt_lookup(input t_wbt_scan s, input logic [3:0] cls);
        logic [3:0] c;
        t_wbt_cell  r;
        c = (cls > CL_QUOTE) ? CL_OTHER : cls;
        r.nxt = wbt_tok_start(c);
        r.act = ACT_NONE;
        unique case (s) inside
            SC_OTHER: begin
                r.act = (c == CL_DOT || c == CL_COLON) ? ACT_NONE : ACT_EMIT;
            end
            SC_ALNUM, SC_N, SC_NB: begin
                unique case (c) inside
                    CL_OTHER:            begin r.nxt = SC_OTHER; r.act = ACT_EMIT; end
                    CL_SPACE:            begin r.nxt = SC_SPACE; r.act = ACT_EMIT; end
                    CL_QUOTE:            begin r.nxt = SC_QUOTE; r.act = ACT_EMIT; end
                    CL_DOT, CL_COLON:    r.nxt = SC_OTHER;
                    default:             r.nxt = SC_ALNUM;
                endcase
                if (s == SC_N && c == CL_B) r.nxt = SC_NB;
                if (s == SC_NB && c == CL_DOT) r.nxt = SC_NBDOT;
            end
            SC_NBDOT: begin
                r.nxt = (c == CL_DOT || c == CL_COLON) ? SC_OTHER : SC_CMT;
            end
            SC_NUM: begin
                unique case (c) inside
                    CL_OTHER: begin r.nxt = SC_OTHER; r.act = ACT_EMIT; end
                    CL_SPACE: begin r.nxt = SC_SPACE; r.act = ACT_EMIT; end
                    CL_QUOTE: begin r.nxt = SC_QUOTE; r.act = ACT_EMIT; end
                    CL_COLON: r.nxt = SC_OTHER;
                    default:  r.nxt = SC_NUM;
                endcase
            end
            SC_QUOTE: begin
                r.nxt = (c == CL_QUOTE) ? SC_QQ : SC_QUOTE;
            end
            SC_QQ: begin
                r.act = (c == CL_QUOTE) ? ACT_NONE : ACT_EMIT;
            end
            SC_CMT: begin
                r.nxt = SC_CMT;
            end
            default: begin
                // space state, and any bad state code
                r.act = (c == CL_SPACE) ? ACT_NONE : ACT_BEGIN;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/wbt_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbt_front
// Scanner: runs the word-formation table on each accepted beat, tracks the
// line state and pushes the words and terminator it produces as one command.
// ----------------------------------------------------------------------------
module wbt_front import wbt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_wbt_in  i_data,
    input  wire logic     i_q_full,
    output logic          o_push,
    output t_wbt_cmd      o_cmd
);

    localparam int PW = (POSITION_BITS >= 16) ? 16 : POSITION_BITS;

    t_wbt_scan         r_scan, n_scan;
    logic [PW-1:0]     r_wbegin, n_wbegin;
    logic              r_in_num, n_in_num;
    logic              r_vopen, n_vopen;
    logic [PW-1:0]     r_vbegin, n_vbegin;
    logic [PW-1:0]     r_vend, n_vend;
    logic [PW-1:0]     r_pos, n_pos;
    logic [15:0]       r_words, n_words;
    logic              r_ovf, n_ovf;

    logic              accept;
    t_wbt_cell         lkup;
    t_wbt_cmd          cmd;
    logic [16:0]       wsum;
    logic [15:0]       wsat;
    logic [PW-1:0]     st;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign lkup    = wbt_lookup(r_scan, i_data.char_class);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= SC_SPACE;
            r_wbegin <= '0;
            r_in_num <= 1'b0;
            r_vopen  <= 1'b0;
            r_vbegin <= '0;
            r_vend   <= '0;
            r_pos    <= '0;
            r_words  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_scan   <= n_scan;
            r_wbegin <= n_wbegin;
            r_in_num <= n_in_num;
            r_vopen  <= n_vopen;
            r_vbegin <= n_vbegin;
            r_vend   <= n_vend;
            r_pos    <= n_pos;
            r_words  <= n_words;
            r_ovf    <= n_ovf;
        end
    end

    always_comb begin
        n_scan   = r_scan;
        n_wbegin = r_wbegin;
        n_in_num = r_in_num;
        n_vopen  = r_vopen;
        n_vbegin = r_vbegin;
        n_vend   = r_vend;
        n_pos    = r_pos;
        n_words  = r_words;
        n_ovf    = r_ovf;
        cmd      = '0;
        st       = r_vopen ? r_vbegin : r_wbegin;

        if (accept && i_data.opcode == OP_CHAR) begin
            if (&r_pos) begin
                // line full: drop the character
                n_ovf = 1'b1;
            end else begin
                if (lkup.act == ACT_EMIT) begin
                    if (r_in_num && r_scan == SC_NUM) begin
                        // numeric word ends: extend the pending run
                        if (!r_vopen) n_vbegin = r_wbegin;
                        n_vopen = 1'b1;
                        n_vend  = r_pos;
                    end else begin
                        if (r_vopen) begin
                            cmd.has_vec   = 1'b1;
                            cmd.vec_start = 16'(r_vbegin);
                            cmd.vec_len   = 16'(r_vend - r_vbegin);
                            n_vopen       = 1'b0;
                        end
                        cmd.has_word   = 1'b1;
                        cmd.word_start = 16'(r_wbegin);
                        cmd.word_len   = 16'(r_pos - r_wbegin);
                    end
                end
                n_scan = lkup.nxt;
                if (lkup.act != ACT_NONE) begin
                    n_wbegin = r_pos;
                    n_in_num = (lkup.nxt == SC_NUM);
                end
                n_pos = r_pos + 1'b1;
            end
        end else if (accept) begin
            if (r_scan == SC_QUOTE) begin
                // open quoted word is dropped
                cmd.has_vec = r_vopen;
            end else if (r_in_num && r_scan == SC_NUM) begin
                cmd.has_word   = 1'b1;
                cmd.word_start = 16'(st);
                cmd.word_len   = 16'(r_pos - st);
            end else begin
                cmd.has_vec    = r_vopen;
                cmd.has_word   = (r_scan != SC_SPACE);
                cmd.word_start = 16'(r_wbegin);
                cmd.word_len   = 16'(r_pos - r_wbegin);
            end
            cmd.vec_start = 16'(r_vbegin);
            cmd.vec_len   = 16'(r_vend - r_vbegin);
            cmd.has_term  = 1'b1;
            cmd.term_cmt  = (r_scan == SC_CMT || r_scan == SC_NBDOT);
            cmd.term_oq   = (r_scan == SC_QUOTE);
            cmd.term_ovf  = r_ovf;
        end

        wsum = {1'b0, r_words} + 17'(cmd.has_vec) + 17'(cmd.has_word);
        wsat = wsum[16] ? 16'hFFFF : wsum[15:0];
        cmd.term_count = cmd.has_term ? wsat : 16'd0;

        if (accept && i_data.opcode == OP_EOL) begin
            n_scan   = SC_SPACE;
            n_wbegin = '0;
            n_in_num = 1'b0;
            n_vopen  = 1'b0;
            n_vbegin = '0;
            n_vend   = '0;
            n_pos    = '0;
            n_words  = '0;
            n_ovf    = 1'b0;
        end else begin
            n_words = wsat;
        end
    end

    assign o_push = accept && (cmd.has_vec || cmd.has_word || cmd.has_term);
    assign o_cmd  = cmd;

endmodule
`default_nettype wire

[hdl/wbt_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbt_queue
// Small command queue between scanner and output sequencer.
// ----------------------------------------------------------------------------
module wbt_queue import wbt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_wbt_cmd i_cmd,
    output logic          o_full,
    input  wire logic     i_pop,
    output t_wbt_cmd      o_head,
    output logic          o_empty
);

    t_wbt_cmd          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

[hdl/wbt_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wbt_back
// Output sequencer: walks the head command one result per beat, in order
// numeric run, word, terminator, into a registered output stage.
// ----------------------------------------------------------------------------
module wbt_back import wbt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_wbt_cmd i_head,
    input  wire logic     i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_wbt_out      o_data
);

    logic [2:0] r_done, n_done;
    logic       r_valid;
    t_wbt_out   r_data, n_data;
    logic [2:0] pend, pick;
    logic       load;

    assign pend = {i_head.has_term, i_head.has_word, i_head.has_vec} & ~r_done;
    assign pick = pend & (~pend + 3'd1);
    assign load = !r_valid || i_ready;
    assign o_pop = load && !i_empty && ((pend & ~pick) == 3'd0);

    always_comb begin
        n_done = r_done;
        if (load && !i_empty) n_done = o_pop ? 3'd0 : (r_done | pick);

        n_data = '0;
        if (pick[0]) begin
            n_data.word_valid  = 1'b1;
            n_data.word_start  = i_head.vec_start;
            n_data.word_length = i_head.vec_len;
        end else if (pick[1]) begin
            n_data.word_valid  = 1'b1;
            n_data.word_start  = i_head.word_start;
            n_data.word_length = i_head.word_len;
        end else begin
            n_data.end_of_line      = 1'b1;
            n_data.word_count       = i_head.term_count;
            n_data.ends_in_comment  = i_head.term_cmt;
            n_data.open_quote_error = i_head.term_oq;
            n_data.line_overflow    = i_head.term_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (load) r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[hdl/word_boundary_tokenizer.sv]
`default_nettype none
// A beat's command is queued first, then each result goes to the registered output stage.
// Throughput: one character beat per cycle while the queue has room; results leave at
// one per cycle while the receiver is ready, with a 4-entry queue between.
// Input ready drops only while that queue is full.
// Reset (synchronous, active low) clears the line state, the queue and output valid.
// ----------------------------------------------------------------------------
// word_boundary_tokenizer
// Splits a stream of classified characters into (start, length) words with
// numeric-run merging, and ends each line with a terminator beat.
// ----------------------------------------------------------------------------
module word_boundary_tokenizer import wbt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_wbt_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_wbt_out      o_out_data
);

    logic     q_full, q_empty, q_push, q_pop;
    t_wbt_cmd q_in, q_head;

    wbt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    wbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    wbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

[bench/tb_word_boundary_tokenizer.sv]
// ----------------------------------------------------------------------------
// tb_word_boundary_tokenizer
// Self-checking bench for the word tokenizer. A short stimulus table is sent
// first, then random lines with their content biased toward words, numeric
// runs and trailing comments, under three sender/receiver idle mixes. Every
// output beat is checked, field by field, against an in-bench predictor of
// the word-formation table, or against the row's own result for typed rows.
// ----------------------------------------------------------------------------
module tb_word_boundary_tokenizer;
    import wbt_pkg::*;

    localparam int          LINE_MAX       = 65535;
    localparam logic [3:0]  CL_BEYOND      = 4'hF;  // out of range, reads as other
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          RANDOM_BEATS   = 460;
    localparam int          N_DIRECTED     = 26;

    localparam int STY_NOISE   = 0;
    localparam int STY_WORDS   = 1;
    localparam int STY_NUMERIC = 2;
    localparam int STY_COMMENT = 3;

    typedef struct packed {
        logic     typed;
        t_wbt_in  beat;
        t_wbt_out tok;
    } t_row;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     beat_valid = 1'b0;
    t_wbt_in  beat_data = '0;
    logic     tok_ready = 1'b0;
    logic     beat_ready;
    logic     tok_valid;
    t_wbt_out tok_data;

    int in_idle_pct = 0;
    int out_stall_pct = 0;

    // predictor state for the current line
    t_wbt_scan   ln_scan;
    logic [15:0] ln_wbeg;
    logic        ln_in_num;
    logic        run_open;
    logic [15:0] run_begin;
    logic [15:0] run_end;
    logic [15:0] ln_pos;
    logic [15:0] ln_words;
    logic        ln_ovf;

    t_wbt_out beat_tokens[$];
    t_wbt_out tokens_due[$];

    int beats_sent = 0;
    int lines_sent = 0;
    int tokens_checked = 0;
    int mismatches = 0;
    int cycles_quiet = 0;

    t_row directed [N_DIRECTED];

    word_boundary_tokenizer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (beat_valid),
        .o_in_ready  (beat_ready),
        .i_in_data   (beat_data),
        .o_out_valid (tok_valid),
        .i_out_ready (tok_ready),
        .o_out_data  (tok_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic t_wbt_scan opening_state(input logic [3:0] c);
        case (c)
            CL_SPACE:       return SC_SPACE;
            CL_ALNUM, CL_B: return SC_ALNUM;
            CL_N:           return SC_N;
            CL_NUM:         return SC_NUM;
            CL_QUOTE:       return SC_QUOTE;
            default:        return SC_OTHER;
        endcase
    endfunction

    function automatic t_wbt_cell next_cell(input t_wbt_scan s, input logic [3:0] c);
        t_wbt_cell t;
        t.nxt = opening_state(c);
        t.act = ACT_EMIT;
        case (s)
            SC_OTHER: begin
                if (c == CL_DOT || c == CL_COLON) t.act = ACT_NONE;
            end
            SC_ALNUM, SC_N, SC_NB: begin
                if (c == CL_DOT || c == CL_COLON) begin
                    t.nxt = SC_OTHER;
                    t.act = ACT_NONE;
                end else if (c != CL_OTHER && c != CL_SPACE && c != CL_QUOTE) begin
                    t.nxt = SC_ALNUM;
                    t.act = ACT_NONE;
                end
                if (s == SC_N && c == CL_B) t.nxt = SC_NB;
                if (s == SC_NB && c == CL_DOT) t.nxt = SC_NBDOT;
            end
            SC_NUM: begin
                if (c == CL_COLON) begin
                    t.nxt = SC_OTHER;
                    t.act = ACT_NONE;
                end else if (c != CL_OTHER && c != CL_SPACE && c != CL_QUOTE) begin
                    t.nxt = SC_NUM;
                    t.act = ACT_NONE;
                end
            end
            SC_NBDOT: begin
                t.nxt = (c == CL_DOT || c == CL_COLON) ? SC_OTHER : SC_CMT;
                t.act = ACT_NONE;
            end
            SC_QUOTE: begin
                t.nxt = (c == CL_QUOTE) ? SC_QQ : SC_QUOTE;
                t.act = ACT_NONE;
            end
            SC_QQ: begin
                if (c == CL_QUOTE) begin
                    t.nxt = SC_QUOTE;
                    t.act = ACT_NONE;
                end
            end
            SC_CMT: begin
                t.nxt = SC_CMT;
                t.act = ACT_NONE;
            end
            default: begin
                t.act = (c == CL_SPACE) ? ACT_NONE : ACT_BEGIN;
            end
        endcase
        return t;
    endfunction

    task automatic clear_line();
        ln_scan   = SC_SPACE;
        ln_wbeg   = '0;
        ln_in_num = 1'b0;
        run_open  = 1'b0;
        run_begin = '0;
        run_end   = '0;
        ln_pos    = '0;
        ln_words  = '0;
        ln_ovf    = 1'b0;
    endtask

    task automatic add_word(input logic [15:0] start, input logic [15:0] len);
        t_wbt_out w;
        w = '0;
        w.word_valid  = 1'b1;
        w.word_start  = start;
        w.word_length = len;
        beat_tokens.push_back(w);
        if (ln_words != 16'hFFFF) ln_words++;
    endtask

    // fills beat_tokens with what one input beat yields
    task automatic tokenize_beat(input t_wbt_in b);
        t_wbt_cell   t;
        logic [3:0]  c;
        logic [15:0] st;
        logic        oq;
        logic        cmt;
        t_wbt_out    term;
        beat_tokens.delete();
        if (b.opcode == OP_CHAR) begin
            c = (b.char_class > CL_QUOTE) ? CL_OTHER : b.char_class;
            if (ln_pos == 16'(LINE_MAX)) begin
                ln_ovf = 1'b1;
                return;
            end
            t = next_cell(ln_scan, c);
            if (t.act == ACT_EMIT) begin
                // a number ending in a space may merge with the next number
                if (ln_in_num && ln_scan == SC_NUM) begin
                    if (!run_open) run_begin = ln_wbeg;
                    run_open = 1'b1;
                    run_end  = ln_pos;
                end else begin
                    if (run_open) begin
                        run_open = 1'b0;
                        add_word(run_begin, run_end - run_begin);
                    end
                    add_word(ln_wbeg, ln_pos - ln_wbeg);
                end
            end
            ln_scan = t.nxt;
            if (t.act != ACT_NONE) begin
                ln_wbeg   = ln_pos;
                ln_in_num = (t.nxt == SC_NUM);
            end
            ln_pos++;
        end else begin
            oq  = (ln_scan == SC_QUOTE);
            cmt = (ln_scan == SC_CMT || ln_scan == SC_NBDOT);
            if (oq) begin
                // open quoted word is dropped, a pending run is not
                if (run_open) add_word(run_begin, run_end - run_begin);
            end else if (ln_in_num && ln_scan == SC_NUM) begin
                st = run_open ? run_begin : ln_wbeg;
                add_word(st, ln_pos - st);
            end else begin
                if (run_open) add_word(run_begin, run_end - run_begin);
                if (ln_scan != SC_SPACE) add_word(ln_wbeg, ln_pos - ln_wbeg);
            end
            term = '0;
            term.end_of_line      = 1'b1;
            term.word_count       = ln_words;
            term.ends_in_comment  = cmt;
            term.open_quote_error = oq;
            term.line_overflow    = ln_ovf;
            beat_tokens.push_back(term);
            clear_line();
        end
    endtask

    // ---------------- stimulus ----------------

    function automatic t_row ch(input logic [3:0] c);
        t_row r;
        r = '0;
        r.beat.opcode     = OP_CHAR;
        r.beat.char_class = c;
        return r;
    endfunction

    function automatic t_row eol();
        t_row r;
        r = '0;
        r.beat.opcode = OP_EOL;
        return r;
    endfunction

    function automatic t_row eol_term(input logic [15:0] n, input logic cmt,
                                      input logic oq, input logic ovf);
        t_row r;
        r = eol();
        r.typed                = 1'b1;
        r.tok.end_of_line      = 1'b1;
        r.tok.word_count       = n;
        r.tok.ends_in_comment  = cmt;
        r.tok.open_quote_error = oq;
        r.tok.line_overflow    = ovf;
        return r;
    endfunction

    task automatic send_beat(input t_wbt_in b, input logic typed, input t_wbt_out tok);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            beat_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        beat_valid <= 1'b1;
        beat_data  <= b;
        do @(posedge clk); while (!beat_ready);
        tokenize_beat(b);
        if (typed) tokens_due.push_back(tok);
        else foreach (beat_tokens[k]) tokens_due.push_back(beat_tokens[k]);
        beats_sent++;
    endtask

    function automatic logic [3:0] pick_class(input int style);
        int r;
        logic [3:0] c;
        r = $urandom_range(0, 99);
        case (style)
            STY_NOISE: c = 4'($urandom_range(0, 15));
            STY_NUMERIC: begin
                if (r < 35)      c = CL_NUM;
                else if (r < 65) c = CL_SPACE;
                else if (r < 75) c = CL_DOT;
                else if (r < 83) c = CL_ALNUM;
                else if (r < 88) c = CL_COLON;
                else if (r < 94) c = CL_OTHER;
                else             c = CL_QUOTE;
            end
            default: begin
                if (r < 30)      c = CL_SPACE;
                else if (r < 45) c = CL_ALNUM;
                else if (r < 55) c = CL_N;
                else if (r < 65) c = CL_B;
                else if (r < 75) c = CL_NUM;
                else if (r < 83) c = CL_OTHER;
                else if (r < 89) c = CL_DOT;
                else if (r < 95) c = CL_COLON;
                else             c = CL_QUOTE;
            end
        endcase
        return c;
    endfunction

    task automatic send_line(input int len, input int style);
        t_wbt_in b;
        int      mark;
        mark = (style == STY_COMMENT && len >= 3) ? $urandom_range(0, len - 3) : -1;
        for (int k = 0; k < len; k++) begin
            b.opcode = OP_CHAR;
            if (mark >= 0 && k == mark)          b.char_class = CL_N;
            else if (mark >= 0 && k == mark + 1) b.char_class = CL_B;
            else if (mark >= 0 && k == mark + 2) b.char_class = CL_DOT;
            else                                 b.char_class = pick_class(style);
            send_beat(b, 1'b0, '0);
        end
        b.opcode     = OP_EOL;
        b.char_class = 4'($urandom_range(0, 15));  // ignored on end of line
        send_beat(b, 1'b0, '0);
        lines_sent++;
    endtask

    task automatic random_lines(input int upto);
        int sel;
        int style;
        while (beats_sent < upto) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)     style = STY_NOISE;
            else if (sel < 5) style = STY_WORDS;
            else if (sel < 8) style = STY_NUMERIC;
            else              style = STY_COMMENT;
            send_line($urandom_range(0, 24), style);
        end
    endtask

    // ---------------- checking ----------------

    function automatic string show(input t_wbt_out t);
        return $sformatf("word=%0d start=%0d len=%0d eol=%0d count=%0d cmt=%0d oq=%0d ovf=%0d",
                         t.word_valid, t.word_start, t.word_length, t.end_of_line,
                         t.word_count, t.ends_in_comment, t.open_quote_error,
                         t.line_overflow);
    endfunction

    function automatic logic same_token(input t_wbt_out a, input t_wbt_out b);
        return a.word_valid === b.word_valid && a.word_start === b.word_start &&
               a.word_length === b.word_length && a.end_of_line === b.end_of_line &&
               a.word_count === b.word_count && a.ends_in_comment === b.ends_in_comment &&
               a.open_quote_error === b.open_quote_error &&
               a.line_overflow === b.line_overflow;
    endfunction

    task automatic note_mismatch(input string what, input t_wbt_out want, input t_wbt_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s\n  expected %s\n  actual   %s", $realtime, what,
                     show(want), show(got));
    endtask

    always @(posedge clk) begin : rx
        t_wbt_out want;
        tok_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        if (rst_n && tok_valid && tok_ready) begin
            if (tokens_due.size() == 0) begin
                note_mismatch("output beat with nothing expected", '0, tok_data);
            end else begin
                want = tokens_due.pop_front();
                if (!same_token(want, tok_data)) note_mismatch("output mismatch", want, tok_data);
            end
            tokens_checked++;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((beat_valid && beat_ready) || (tok_valid && tok_ready)) cycles_quiet <= 0;
            else cycles_quiet <= cycles_quiet + 1;
            if (cycles_quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, tokens_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        directed = '{
            eol_term(16'd0, 1'b0, 1'b0, 1'b0),  // empty line right after reset
            ch(CL_QUOTE),
            eol_term(16'd0, 1'b0, 1'b1, 1'b0),  // line ends inside a quote
            ch(CL_N), ch(CL_B), ch(CL_DOT), ch(CL_ALNUM), eol(),  // trailing comment
            ch(CL_NUM), ch(CL_SPACE), ch(CL_NUM), ch(CL_DOT), ch(CL_SPACE),
            ch(CL_NUM), eol(),                  // numeric run still open at end of line
            ch(CL_NUM), ch(CL_SPACE), ch(CL_OTHER), ch(CL_COLON), ch(CL_BEYOND),
            ch(CL_QUOTE), ch(CL_ALNUM), ch(CL_QUOTE), ch(CL_QUOTE), ch(CL_SPACE),
            eol()
        };
        clear_line();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        out_stall_pct = 30;
        foreach (directed[k]) send_beat(directed[k].beat, directed[k].typed, directed[k].tok);

        in_idle_pct   = 6;
        out_stall_pct = 82;
        random_lines(RANDOM_BEATS / 3);
        in_idle_pct   = 82;
        out_stall_pct = 6;
        random_lines(2 * RANDOM_BEATS / 3);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_lines(RANDOM_BEATS);
        beat_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d lines, %0d input beats, %0d output beats checked",
                 lines_sent, beats_sent, tokens_checked);
        $display("idle mixes: sender light/receiver heavy, reverse, none; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
